### sv/ellipse_fan_vertex_generator_top_macros.svh
// Assertion macros for the ellipse fan vertex generator.
`ifndef ELLIPSE_FAN_VERTEX_GENERATOR_TOP_MACROS_SVH
`define ELLIPSE_FAN_VERTEX_GENERATOR_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define EFV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define EFV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/efv_pkg.sv
// Package: shared constants, types and tables for the ellipse fan vertex generator.
`default_nettype none
package efv_pkg;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 14;
  localparam int CW             = 33;  // Q1.30 plus guard
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS_X = 3'd2;
  localparam logic [2:0] REG_RADIUS_Y = 3'd3;
  localparam logic [2:0] REG_POINTS   = 3'd4;
  localparam logic [2:0] REG_SECTOR   = 3'd5;
  localparam logic [2:0] REG_ROTATE   = 3'd6;

  // arctangent per step in turn units
  function automatic logic signed [17:0] atan_turn(input int k);
    case (k)
      0: atan_turn = 18'sd8192;
      1: atan_turn = 18'sd4836;
      2: atan_turn = 18'sd2555;
      3: atan_turn = 18'sd1297;
      4: atan_turn = 18'sd651;
      5: atan_turn = 18'sd326;
      6: atan_turn = 18'sd163;
      7: atan_turn = 18'sd81;
      8: atan_turn = 18'sd41;
      9: atan_turn = 18'sd20;
      10: atan_turn = 18'sd10;
      11: atan_turn = 18'sd5;
      12: atan_turn = 18'sd3;
      13: atan_turn = 18'sd1;
      default: atan_turn = 18'sd0;
    endcase
  endfunction

  // per-vertex control that travels down the pipe
  typedef struct packed {
    logic valid;
    logic center;
    logic oor;
  } efv_ctl_t;
endpackage
`default_nettype wire

### sv/ellipse_fan_vertex_generator_top.sv
// Top level: config registers, angle, CORDIC, scale/rotate and saturation pipeline.
//   channel | handshake        | word
//   config  | cfg_valid/ready  | cfg_index, cfg_data
//   input   | start, busy      | vertex_index
//   result  | done strobe      | vertex_x, vertex_y, out_of_range
// One index per cycle; busy is never high. Each index passes through the
// four-stage angle divider, fifteen CORDIC stages, the two multiply
// stages and the output register. Synchronous reset clears the valid
// pipe and loads the config defaults. The receiver cannot stall;
// results leave on done.
`default_nettype none
`include "ellipse_fan_vertex_generator_top_macros.svh"
module ellipse_fan_vertex_generator_top import efv_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic start,
  output logic      busy,
  input  wire logic [6:0] vertex_index,
  output logic      done,
  output logic signed [COORD_BITS-1:0] vertex_x,
  output logic signed [COORD_BITS-1:0] vertex_y,
  output logic      out_of_range
);
  localparam int NW  = $clog2(MAX_POINTS+1);
  localparam int LAT = 4 + CORDIC_STEPS + 1 + 3;

  logic signed [15:0] center_x, center_y;
  logic [14:0] radius_x, radius_y;
  logic [6:0]  point_count;
  logic [16:0] sector_angle;
  logic [15:0] rotation_angle;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0; center_y <= '0;
      radius_x <= 15'd16384; radius_y <= 15'd16384;
      point_count <= 7'd32; sector_angle <= 17'd65536; rotation_angle <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data[15:0];
        REG_CENTER_Y: center_y <= cfg_data[15:0];
        REG_RADIUS_X: radius_x <= cfg_data[14:0];
        REG_RADIUS_Y: radius_y <= cfg_data[14:0];
        REG_POINTS:   point_count <= cfg_data[6:0];
        REG_SECTOR:   sector_angle <= cfg_data[16:0];
        REG_ROTATE:   rotation_angle <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // clamp step count and classify index
  logic [NW-1:0] n_eff;
  logic [6:0]    step;
  efv_ctl_t      ctl_in;
  always_comb begin
    if (point_count < 7'd2) n_eff = NW'(2);
    else if (32'(point_count) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
    else n_eff = NW'(point_count);
    step = vertex_index - 7'd1;
    ctl_in.valid  = start;
    ctl_in.center = (vertex_index == 7'd0) || (32'(vertex_index) > 32'(n_eff) + 1);
    ctl_in.oor    = (vertex_index != 7'd0) && (32'(vertex_index) > 32'(n_eff) + 1);
  end

  efv_ctl_t ctl [LAT+1];
  assign ctl[0] = ctl_in;
  for (genvar s = 0; s < LAT; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) ctl[s+1] <= '0;
      else ctl[s+1] <= ctl[s];
    end
  end

  logic [15:0] angle;
  efv_angle #(.MAX_POINTS(MAX_POINTS)) u_angle (
    .clk(clk), .step(step), .sector(sector_angle), .n(n_eff), .angle(angle));

  logic signed [CW-1:0] c1, s1, c2, s2;
  efv_cordic u_pt  (.clk(clk), .angle(angle), .cos_q(c1), .sin_q(s1));
  efv_cordic u_rot (.clk(clk), .angle(rotation_angle), .cos_q(c2), .sin_q(s2));

  // scale by radii
  logic signed [CW+16:0] mx, my;
  logic signed [17:0] px, py;
  always_ff @(posedge clk) begin
    mx <= (CW+17)'(c1) * (CW+17)'($signed({1'b0, radius_x}));
    my <= (CW+17)'(s1) * (CW+17)'($signed({1'b0, radius_y}));
  end
  assign px = 18'((mx + (CW+17)'(1 <<< 29)) >>> 30);
  assign py = 18'((my + (CW+17)'(1 <<< 29)) >>> 30);

  // rotate: four products, then sum
  logic signed [CW+18:0] pxc, pys, pxs, pyc;
  always_ff @(posedge clk) begin
    pxc <= (CW+19)'(px) * (CW+19)'(c2);
    pys <= (CW+19)'(py) * (CW+19)'(s2);
    pxs <= (CW+19)'(px) * (CW+19)'(s2);
    pyc <= (CW+19)'(py) * (CW+19)'(c2);
  end
  logic signed [CW+19:0] sx, sy;
  logic signed [CW+19:0] vx, vy;
  assign sx = (CW+20)'(pxc) - (CW+20)'(pys) + (CW+20)'(1 <<< 29);
  assign sy = (CW+20)'(pxs) + (CW+20)'(pyc) + (CW+20)'(1 <<< 29);

  logic signed [CW+19:0] hi_lim, lo_lim;
  assign hi_lim = (CW+20)'((64'sd1 <<< (COORD_BITS-1)) - 64'sd1);
  assign lo_lim = -hi_lim - (CW+20)'(1);
  logic signed [CW+19:0] cx, cy;
  assign cx = (CW+20)'(center_x);
  assign cy = (CW+20)'(center_y);

  // final add, center select, saturation
  always_comb begin
    if (ctl[LAT-1].center) begin
      vx = cx; vy = cy;
    end else begin
      vx = cx + (sx >>> 30);
      vy = cy + (sy >>> 30);
    end
  end
  always_ff @(posedge clk) begin
    vertex_x <= (vx > hi_lim) ? COORD_BITS'(hi_lim) :
                (vx < lo_lim) ? COORD_BITS'(lo_lim) : COORD_BITS'(vx);
    vertex_y <= (vy > hi_lim) ? COORD_BITS'(hi_lim) :
                (vy < lo_lim) ? COORD_BITS'(lo_lim) : COORD_BITS'(vy);
    out_of_range <= ctl[LAT-1].oor;
  end
  assign done = ctl[LAT].valid;

  // checks
  `EFV_ASSERT_IMP(a_oor_center, clk, rst, ctl[LAT-1].oor, ctl[LAT-1].center)
  `EFV_ASSERT_NEXT(a_latency, clk, rst, ctl[LAT-1].valid, done)
  `EFV_ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy && cfg_ready)
endmodule
`default_nettype wire

### sv/efv_cordic.sv
// Pipelined CORDIC: one rotation step per stage, sine and cosine of a turn angle.
`default_nettype none
module efv_cordic import efv_pkg::*; (
  input  wire logic                 clk,
  input  wire logic [15:0]          angle,
  output logic signed [CW-1:0]      cos_q,
  output logic signed [CW-1:0]      sin_q
);
  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [17:0]   zs [CORDIC_STEPS+1];
  logic                 fl [CORDIC_STEPS+1];

  // fold angle into [-quarter, quarter)
  always_ff @(posedge clk) begin
    xs[0] <= CORDIC_GAIN;
    ys[0] <= '0;
    if (angle < 16'd16384) begin
      zs[0] <= 18'(angle); fl[0] <= 1'b0;
    end else if (angle >= 16'd49152) begin
      zs[0] <= 18'(angle) - 18'sd65536; fl[0] <= 1'b0;
    end else begin
      zs[0] <= 18'(angle) - 18'sd32768; fl[0] <= 1'b1;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      fl[k+1] <= fl[k];
      if (!zs[k][17]) begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - atan_turn(k);
      end else begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + atan_turn(k);
      end
    end
  end

  assign cos_q = fl[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
  assign sin_q = fl[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
endmodule
`default_nettype wire

### sv/efv_angle.sv
// Point angle: (i-1)*sector/n rounded, by reciprocal multiply and correction.
`default_nettype none
module efv_angle import efv_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic [6:0]  step,
  input  wire logic [16:0] sector,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0] n,
  output logic [15:0]      angle
);
  localparam int NW = $clog2(MAX_POINTS+1);
  localparam int PW = 7 + 17 + NW;     // numerator width
  localparam int RS = PW;              // reciprocal shift
  localparam int RW = RS + 1;

  logic [PW-1:0] num1;
  logic [NW-1:0] n1, n2, n3;
  logic [RW-1:0] recip1;
  logic [PW-1:0] num2, num3;
  logic [PW+RW-1:0] prod2;
  logic [PW-1:0] q3;
  logic [PW+NW-1:0] qn;
  logic [PW-1:0] rem;
  logic [RW-1:0] recip_tab [MAX_POINTS+1];

  // constant table of ceil(2^RS / n); counts below two never occur
  for (genvar j = 0; j <= MAX_POINTS; j++) begin : g_recip
    if (j < 2) begin : g_unused
      assign recip_tab[j] = '0;
    end else begin : g_val
      assign recip_tab[j] = RW'(((64'd1 << RS) + 64'(j) - 64'd1) / 64'(j));
    end
  end

  // stage 1: numerator, reciprocal looked up
  always_ff @(posedge clk) begin
    num1   <= PW'(step) * PW'(sector) + PW'(n >> 1);
    n1     <= n;
    recip1 <= recip_tab[n];
  end
  // stage 2: estimate
  always_ff @(posedge clk) begin
    prod2 <= (PW+RW)'(num1) * (PW+RW)'(recip1);
    num2  <= num1;
    n2    <= n1;
  end
  // stage 3: quotient estimate, then fix by one
  always_ff @(posedge clk) begin
    q3   <= PW'(prod2 >> RS);
    num3 <= num2;
    n3   <= n2;
  end
  assign qn  = (PW+NW)'(q3) * (PW+NW)'(n3);
  assign rem = num3 - PW'(qn);
  always_ff @(posedge clk) begin
    if (qn > (PW+NW)'(num3)) angle <= 16'(q3 - PW'(1));
    else if (rem >= PW'(n3)) angle <= 16'(q3 + PW'(1));
    else angle <= 16'(q3);
  end
endmodule
`default_nettype wire
